>>> rtl/core/plt_pkg.sv
package plt_pkg;

	// Field and register widths
	localparam int SAMPLE_W = 18;
	localparam int MAG_W    = 17;
	localparam int RESULT_W = 17;
	localparam int CFG_W    = 17;
	localparam int IDX_W    = 2;
	localparam int GAMMA_W  = 16;
	localparam int SCALE_W  = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_INVERSE = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAMMA   = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE   = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX     = 2'd3;

	// Register reset values
	localparam logic [GAMMA_W-1:0] GAMMA_RST = 16'd9011;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4096;
	localparam logic [MAG_W-1:0]   MAX_RST   = 17'd32768;

	// Defaults for the top-level parameters
	localparam int FRAC_BITS_DEF  = 15;
	localparam int ITERATIONS_DEF = 16;

	// Q1.30 mantissa, Q4.12 scale and gamma, integer part of a logarithm
	localparam int MANT_W     = 31;
	localparam int SCALE_FRAC = 12;
	localparam int CINT_W     = 7;
	localparam int SHIFT_W    = 5;

	// Square root unit: 64-bit radicand, 32 root bits, four per stage
	localparam int ROOT_W     = 64;
	localparam int ROOT_BITS  = 32;
	localparam int ROOT_STEPS = 4;

	localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

	typedef struct packed {
		logic vld;
		logic inv;
		logic zero;
		logic hi;
		logic lo;
	} plt_ctl_t;

	// Index of the leading one; zero for a zero word
	function automatic logic [SHIFT_W-1:0] msb_index(input logic [MAG_W-1:0] v);
		logic [SHIFT_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) p = SHIFT_W'(i);
		end
		return p;
	endfunction

endpackage

>>> rtl/core/plt_sample_if.sv
interface plt_sample_if;
	import plt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

>>> rtl/core/plt_result_if.sv
interface plt_result_if;
	import plt_pkg::*;

	logic                valid;
	logic                ready;
	logic [RESULT_W-1:0] result;

	modport source(output valid, output result, input ready);
	modport sink(input valid, input result, output ready);
endinterface

>>> rtl/core/plt_log_cell.sv
module plt_log_cell #(
	parameter int FW = 16,
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  plt_pkg::plt_ctl_t           ctl_i,
	input  logic [plt_pkg::MANT_W-1:0]  mx_i,
	input  logic [plt_pkg::MANT_W-1:0]  ma_i,
	input  logic [FW-1:0]               fx_i,
	input  logic [FW-1:0]               fa_i,
	input  logic [SW-1:0]               side_i,
	output plt_pkg::plt_ctl_t           ctl_o,
	output logic [plt_pkg::MANT_W-1:0]  mx_o,
	output logic [plt_pkg::MANT_W-1:0]  ma_o,
	output logic [FW-1:0]               fx_o,
	output logic [FW-1:0]               fa_o,
	output logic [SW-1:0]               side_o
);
	import plt_pkg::*;

	logic [2*MANT_W-1:0] sqx, sqa;
	logic [MANT_W:0]     tx, ta;
	logic [MANT_W-1:0]   nx, na;

	// Square both mantissas; a square of two or more yields a one bit and is halved
	always_comb begin
		sqx = mx_i * mx_i;
		sqa = ma_i * ma_i;
		tx  = sqx[2*MANT_W-1:MANT_W-1];
		ta  = sqa[2*MANT_W-1:MANT_W-1];
		nx  = tx[MANT_W] ? tx[MANT_W:1] : tx[MANT_W-1:0];
		na  = ta[MANT_W] ? ta[MANT_W:1] : ta[MANT_W-1:0];
	end

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			mx_o   <= nx;
			ma_o   <= na;
			fx_o   <= {fx_i[FW-2:0], tx[MANT_W]};
			fa_o   <= {fa_i[FW-2:0], ta[MANT_W]};
			side_o <= side_i;
		end
	end

endmodule

>>> rtl/core/plt_div_cell.sv
module plt_div_cell #(
	parameter int DW = 35,
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [plt_pkg::GAMMA_W-1:0] divisor,
	input  plt_pkg::plt_ctl_t           ctl_i,
	input  logic [plt_pkg::GAMMA_W-1:0] rem_i,
	input  logic [DW-1:0]               quo_i,
	input  logic [SW-1:0]               side_i,
	output plt_pkg::plt_ctl_t           ctl_o,
	output logic [plt_pkg::GAMMA_W-1:0] rem_o,
	output logic [DW-1:0]               quo_o,
	output logic [SW-1:0]               side_o
);
	import plt_pkg::*;

	logic [GAMMA_W:0]   trial, diff;
	logic               take;
	logic [GAMMA_W-1:0] rem_n;

	// One restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_i, quo_i[DW-1]};
		diff  = trial - {1'b0, divisor};
		take  = trial >= {1'b0, divisor};
		rem_n = take ? diff[GAMMA_W-1:0] : trial[GAMMA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= rem_n;
			quo_o  <= {quo_i[DW-2:0], take};
			side_o <= side_i;
		end
	end

endmodule

>>> rtl/core/plt_exp_cell.sv
module plt_exp_cell #(
	parameter int FW = 16,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  plt_pkg::plt_ctl_t          ctl_i,
	input  logic [plt_pkg::MANT_W-1:0] r_i,
	input  logic [FW-1:0]              f_i,
	input  logic [SW-1:0]              side_i,
	output plt_pkg::plt_ctl_t          ctl_o,
	output logic [plt_pkg::MANT_W-1:0] r_o,
	output logic [FW-1:0]              f_o,
	output logic [SW-1:0]              side_o
);
	import plt_pkg::*;

	localparam int NS = ROOT_BITS / ROOT_STEPS;

	logic [MANT_W:0]   r_dbl;
	logic [ROOT_W-1:0] v_in  [NS];
	logic [ROOT_W-1:0] q_in  [NS];
	logic [ROOT_W-1:0] v_nxt [NS];
	logic [ROOT_W-1:0] q_nxt [NS];
	logic [ROOT_W-1:0] v_q   [NS];
	logic [ROOT_W-1:0] q_q   [NS];
	plt_ctl_t          ctl_q [NS];
	logic [FW-1:0]     f_q   [NS];
	logic [SW-1:0]     side_q[NS];

	// Double the mantissa when this fraction bit is set, then take the root of r * 2^30
	always_comb begin
		r_dbl   = f_i[0] ? {r_i, 1'b0} : {1'b0, r_i};
		v_in[0] = {2'b0, r_dbl, 30'b0};
		q_in[0] = '0;
	end

	for (genvar k = 0; k < NS; k++) begin : g_root
		if (k > 0) begin : g_link
			assign v_in[k] = v_q[k-1];
			assign q_in[k] = q_q[k-1];
		end

		// Four digit-by-digit root steps per stage
		always_comb begin
			logic [ROOT_W-1:0] vv, qq, bb;
			vv = v_in[k];
			qq = q_in[k];
			for (int j = 0; j < ROOT_STEPS; j++) begin
				bb = ROOT_W'(1) << (ROOT_W - 2 - 2 * (k * ROOT_STEPS + j));
				if (vv >= qq + bb) begin
					vv = vv - (qq + bb);
					qq = (qq >> 1) + bb;
				end else begin
					qq = qq >> 1;
				end
			end
			v_nxt[k] = vv;
			q_nxt[k] = qq;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[k] <= '0;
			end else if (en) begin
				ctl_q[k] <= (k == 0) ? ctl_i : ctl_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_q[k]    <= v_nxt[k];
				q_q[k]    <= q_nxt[k];
				f_q[k]    <= (k == 0) ? (f_i >> 1) : f_q[k-1];
				side_q[k] <= (k == 0) ? side_i : side_q[k-1];
			end
		end
	end

	assign ctl_o  = ctl_q[NS-1];
	assign r_o    = q_q[NS-1][MANT_W-1:0];
	assign f_o    = f_q[NS-1];
	assign side_o = side_q[NS-1];

endmodule

>>> rtl/core/power_law_transfer.sv
// Power-law transfer: forward mode gives scale * x^(1/gamma) of the clipped
// sample, inverse mode gives (x/scale)^gamma clipped to max_value; negative
// and zero samples give zero, results saturate at the top of Q2.15. The block
// takes one sample per clock and gives one result per clock while the output
// is not stalled. The pipeline is one input stage, ITERATIONS squaring cells
// for the logarithms, one multiply stage, a restoring divider of ITERATIONS
// + 19 one-bit cells, two exponent stages, ITERATIONS root cells of eight
// stages each, and the output register. The whole chain stalls only while a
// finished result waits to be taken.
module power_law_transfer #(
	parameter int FRAC_BITS  = plt_pkg::FRAC_BITS_DEF,
	parameter int ITERATIONS = plt_pkg::ITERATIONS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	plt_sample_if.sink                sample_ch,
	plt_result_if.source              result_ch,
	input  logic                      cfg_we,
	input  logic [plt_pkg::IDX_W-1:0] cfg_index,
	input  logic [plt_pkg::CFG_W-1:0] cfg_data
);
	import plt_pkg::*;

	localparam int FW  = ITERATIONS;
	localparam int LW  = CINT_W + FW;
	localparam int DW  = LW + SCALE_FRAC;
	localparam int PW  = LW + 1 + GAMMA_W + 1;
	localparam int LRW = DW + 2;
	localparam int NW  = LRW - FW;
	localparam int DSW = 1 + LW + PW;
	localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << (MANT_W - 1);

	// Configuration registers
	logic               inv_q;
	logic [GAMMA_W-1:0] gamma_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MAG_W-1:0]   max_q;
	logic [GAMMA_W-1:0] g_eff;
	logic [SCALE_W-1:0] a_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q   <= 1'b0;
			gamma_q <= GAMMA_RST;
			scale_q <= SCALE_RST;
			max_q   <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERSE: inv_q   <= cfg_data[0];
				REG_GAMMA:   gamma_q <= cfg_data[GAMMA_W-1:0];
				REG_SCALE:   scale_q <= cfg_data[SCALE_W-1:0];
				REG_MAX:     max_q   <= cfg_data[MAG_W-1:0];
				default:     ;
			endcase
		end
	end

	assign g_eff = (gamma_q == '0) ? GAMMA_W'(1) : gamma_q;
	assign a_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	// Global advance: hold everything while the result register is full and stalled
	logic adv;
	logic res_vld_q;
	logic [RESULT_W-1:0] res_q;

	assign adv             = !res_vld_q || result_ch.ready;
	assign sample_ch.ready = adv;

	// Input stage: clamp, clip, normalise
	logic [MAG_W-1:0]   x_pos, x_clip;
	logic [SHIFT_W-1:0] ex, ea;
	logic [CINT_W-1:0]  cx_n, ca_n;
	plt_ctl_t           ctl_s1;
	logic [MANT_W-1:0]  mx_s1, ma_s1;
	logic [CINT_W-1:0]  cx_s1, ca_s1;

	always_comb begin
		x_pos  = sample_ch.sample[SAMPLE_W-1] ? '0 : sample_ch.sample[MAG_W-1:0];
		x_clip = (!inv_q && (x_pos > max_q)) ? max_q : x_pos;
		ex     = msb_index(x_clip);
		ea     = msb_index({1'b0, a_eff});
		cx_n   = {2'b0, ex} - CINT_W'(FRAC_BITS);
		ca_n   = {2'b0, ea} - CINT_W'(SCALE_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= sample_ch.valid;
			ctl_s1.inv  <= inv_q;
			ctl_s1.zero <= (x_clip == '0);
			ctl_s1.hi   <= 1'b0;
			ctl_s1.lo   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1 <= MANT_W'(x_clip) << (SHIFT_W'(MANT_W - 1) - ex);
			ma_s1 <= MANT_W'(a_eff) << (SHIFT_W'(MANT_W - 1) - ea);
			cx_s1 <= cx_n;
			ca_s1 <= ca_n;
		end
	end

	// Logarithm fractions, one bit per cell
	plt_ctl_t            ctl_l [FW+1];
	logic [MANT_W-1:0]   mx_l  [FW+1];
	logic [MANT_W-1:0]   ma_l  [FW+1];
	logic [FW-1:0]       fx_l  [FW+1];
	logic [FW-1:0]       fa_l  [FW+1];
	logic [2*CINT_W-1:0] side_l[FW+1];

	assign ctl_l[0]  = ctl_s1;
	assign mx_l[0]   = mx_s1;
	assign ma_l[0]   = ma_s1;
	assign fx_l[0]   = '0;
	assign fa_l[0]   = '0;
	assign side_l[0] = {cx_s1, ca_s1};

	for (genvar i = 0; i < FW; i++) begin : g_log
		plt_log_cell #(.FW(FW), .SW(2 * CINT_W)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctl_i (ctl_l[i]),
			.mx_i  (mx_l[i]),
			.ma_i  (ma_l[i]),
			.fx_i  (fx_l[i]),
			.fa_i  (fa_l[i]),
			.side_i(side_l[i]),
			.ctl_o (ctl_l[i+1]),
			.mx_o  (mx_l[i+1]),
			.ma_o  (ma_l[i+1]),
			.fx_o  (fx_l[i+1]),
			.fa_o  (fa_l[i+1]),
			.side_o(side_l[i+1])
		);
	end

	// Multiply stage: dividend for forward mode, exact product for inverse mode
	logic signed [LW-1:0] lx, la;
	logic signed [LW:0]   dlt;
	logic [LW-1:0]        mag;
	plt_ctl_t             ctl_s2;
	logic [DW-1:0]        dvd_s2;
	logic [LW-1:0]        la_s2;
	logic signed [PW-1:0] prod_s2;
	logic                 neg_s2;

	always_comb begin
		lx  = {side_l[FW][2*CINT_W-1:CINT_W], fx_l[FW]};
		la  = {side_l[FW][CINT_W-1:0], fa_l[FW]};
		dlt = {lx[LW-1], lx} - {la[LW-1], la};
		mag = lx[LW-1] ? (LW'(0) - lx) : lx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_l[FW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s2  <= {mag, SCALE_FRAC'(0)};
			la_s2   <= la;
			prod_s2 <= dlt * $signed({1'b0, g_eff});
			neg_s2  <= lx[LW-1];
		end
	end

	// Restoring divider by gamma, one quotient bit per cell
	plt_ctl_t           ctl_d [DW+1];
	logic [GAMMA_W-1:0] rem_d [DW+1];
	logic [DW-1:0]      quo_d [DW+1];
	logic [DSW-1:0]     side_d[DW+1];

	assign ctl_d[0]  = ctl_s2;
	assign rem_d[0]  = '0;
	assign quo_d[0]  = dvd_s2;
	assign side_d[0] = {neg_s2, la_s2, prod_s2};

	for (genvar i = 0; i < DW; i++) begin : g_div
		plt_div_cell #(.DW(DW), .SW(DSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.divisor(g_eff),
			.ctl_i  (ctl_d[i]),
			.rem_i  (rem_d[i]),
			.quo_i  (quo_d[i]),
			.side_i (side_d[i]),
			.ctl_o  (ctl_d[i+1]),
			.rem_o  (rem_d[i+1]),
			.quo_o  (quo_d[i+1]),
			.side_o (side_d[i+1])
		);
	end

	// Exponent: floor of the signed quotient plus log2(scale), or the floored product
	logic            d_neg;
	logic [LW-1:0]   d_la;
	logic [PW-1:0]   d_prod;
	logic [LRW-1:0]  q_ext, q_flr, lr_fwd, lr_inv;
	plt_ctl_t        ctl_s3;
	logic [LRW-1:0]  lr_s3;

	always_comb begin
		{d_neg, d_la, d_prod} = side_d[DW];
		q_ext    = {2'b0, quo_d[DW]};
		q_flr    = d_neg ? (LRW'(0) - (q_ext + LRW'(rem_d[DW] != '0))) : q_ext;
		lr_fwd   = q_flr + {{(LRW-LW){d_la[LW-1]}}, d_la};
		lr_inv   = LRW'($signed(d_prod) >>> SCALE_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_d[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lr_s3 <= ctl_d[DW].inv ? lr_inv : lr_fwd;
		end
	end

	// Split into integer and fraction, flag the out-of-range shifts
	logic [NW:0]        s_n, hi_t, lo_t, sh_t;
	plt_ctl_t           ctl_s4;
	logic [FW-1:0]      f_s4;
	logic [SHIFT_W-1:0] sh_s4;

	always_comb begin
		s_n  = {lr_s3[LRW-1], lr_s3[LRW-1:FW]} + (NW+1)'(FRAC_BITS);
		hi_t = s_n - (NW+1)'(RESULT_W);
		lo_t = s_n + (NW+1)'(1);
		sh_t = (NW+1)'(MANT_W - 1) - s_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4.vld  <= ctl_s3.vld;
			ctl_s4.inv  <= ctl_s3.inv;
			ctl_s4.zero <= ctl_s3.zero;
			ctl_s4.hi   <= !hi_t[NW];
			ctl_s4.lo   <= lo_t[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4  <= lr_s3[FW-1:0];
			sh_s4 <= sh_t[SHIFT_W-1:0];
		end
	end

	// exp2 fraction, one square root per cell, least significant bit first
	plt_ctl_t           ctl_e [FW+1];
	logic [MANT_W-1:0]  r_e   [FW+1];
	logic [FW-1:0]      f_e   [FW+1];
	logic [SHIFT_W-1:0] side_e[FW+1];

	assign ctl_e[0]  = ctl_s4;
	assign r_e[0]    = MANT_ONE;
	assign f_e[0]    = f_s4;
	assign side_e[0] = sh_s4;

	for (genvar i = 0; i < FW; i++) begin : g_exp
		plt_exp_cell #(.FW(FW), .SW(SHIFT_W)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.ctl_i (ctl_e[i]),
			.r_i   (r_e[i]),
			.f_i   (f_e[i]),
			.side_i(side_e[i]),
			.ctl_o (ctl_e[i+1]),
			.r_o   (r_e[i+1]),
			.f_o   (f_e[i+1]),
			.side_o(side_e[i+1])
		);
	end

	// Round, saturate and clip into the result register
	logic [MANT_W:0]     rnd, y;
	logic [RESULT_W-1:0] y_sat, y_fin;
	plt_ctl_t            ctl_f;

	always_comb begin
		ctl_f = ctl_e[FW];
		rnd   = {1'b0, r_e[FW]} + ((MANT_W+1)'(1) << (side_e[FW] - SHIFT_W'(1)));
		y     = rnd >> side_e[FW];
		y_sat = (y > (MANT_W+1)'(RESULT_MAX)) ? RESULT_MAX : y[RESULT_W-1:0];
		if (ctl_f.zero || ctl_f.lo) begin
			y_fin = '0;
		end else begin
			y_fin = ctl_f.hi ? RESULT_MAX : y_sat;
			if (ctl_f.inv && (y_fin > max_q)) y_fin = max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= ctl_f.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= y_fin;
		end
	end

	assign result_ch.valid  = res_vld_q;
	assign result_ch.result = res_q;

endmodule

>>> rtl/core/plt_checker.sv
module plt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [plt_pkg::RESULT_W-1:0]  out_result
);
	import plt_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result))
		else $error("stalled result beat changed");

	// A stalled output stalls the input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the output is stalled");

	// A free or draining output lets the input in
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input held although the output can move");

endmodule

bind power_law_transfer plt_checker u_plt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_result(result_ch.result)
);

>>> sim/tb_power_law_transfer.sv
`timescale 1ns / 1ps

module tb_power_law_transfer;
	import plt_pkg::*;

	localparam int SETTLE_CYCLES = 220;
	localparam int STALL_LIMIT   = 6000;
	localparam int NUM_PHASES    = 12;
	localparam int RAND_PER_PHASE = 118;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	plt_sample_if smp_ch();
	plt_result_if res_ch();

	power_law_transfer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (smp_ch),
		.result_ch (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the transfer registers
	logic               mdl_inverse;
	logic [GAMMA_W-1:0] mdl_gamma;
	logic [SCALE_W-1:0] mdl_scale;
	logic [MAG_W-1:0]   mdl_max;

	logic signed [SAMPLE_W-1:0] pending_samples[$];
	logic [RESULT_W-1:0]        expected_results[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int mismatch_count;
	int quiet_cycles;

	always #5 clk = ~clk;

	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Log2 with 16 fraction bits, fraction found by repeated squaring
	function automatic longint log2_q16(longint unsigned v, int vfrac);
		int e;
		longint unsigned m;
		longint unsigned f;
		e = 0;
		while (e < 62 && (v >> (e + 1)) != 0) e++;
		m = v << (30 - e);
		f = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			f <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				f |= 1;
			end
		end
		return longint'(e - vfrac) * 65536 + longint'(f);
	endfunction

	// Exp2 of a 16-fraction-bit exponent, result in Q2.15 with saturation
	function automatic logic [RESULT_W-1:0] exp2_q15(longint lr);
		longint n;
		longint unsigned f;
		longint s;
		longint unsigned r;
		longint unsigned y;
		int sh;
		n = floor_div(lr, 65536);
		f = longint'(lr - n * 65536);
		s = n + 15;
		if (s >= 17) return RESULT_MAX;
		if (s < -1) return '0;
		r = 64'd1 << 30;
		for (int i = 0; i < 16; i++) begin
			if (f[i]) r <<= 1;
			r = root_floor(r << 30);
		end
		sh = 30 - int'(s);
		y = (r + (64'd1 << (sh - 1))) >> sh;
		if (y > 131071) y = 131071;
		return RESULT_W'(y);
	endfunction

	function automatic logic [RESULT_W-1:0] transfer_of(logic signed [SAMPLE_W-1:0] smp);
		longint unsigned x;
		longint g;
		longint a;
		longint lx;
		longint la;
		logic [RESULT_W-1:0] y;
		x = (smp < 0) ? 0 : longint'(smp);
		g = (mdl_gamma == 0) ? 1 : longint'(mdl_gamma);
		a = (mdl_scale == 0) ? 1 : longint'(mdl_scale);
		y = '0;
		if (mdl_inverse) begin
			if (x != 0) begin
				lx = log2_q16(x, 15);
				la = log2_q16(a, 12);
				y = exp2_q15(floor_div((lx - la) * g, 4096));
				if (y > mdl_max) y = mdl_max;
			end
		end else begin
			if (x > mdl_max) x = mdl_max;
			if (x != 0) begin
				lx = log2_q16(x, 15);
				la = log2_q16(a, 12);
				y = exp2_q15(floor_div(lx * 4096, g) + la);
			end
		end
		return y;
	endfunction

	// Sample driver: hold a beat until taken, idle at random between beats
	always @(posedge clk) begin
		if (!smp_ch.valid || smp_ch.ready) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				smp_ch.valid  <= 1'b1;
				smp_ch.sample <= pending_samples.pop_front();
			end else begin
				smp_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink back-pressure
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor: predict on each accepted sample, check each accepted result
	always @(posedge clk) begin
		if (arst_n && smp_ch.valid && smp_ch.ready)
			expected_results.push_back(transfer_of(smp_ch.sample));
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d with nothing outstanding", res_ch.result);
			end else begin
				logic [RESULT_W-1:0] want;
				want = expected_results.pop_front();
				if (res_ch.result !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %0d, got %0d", want, res_ch.result);
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** power_law_transfer: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INVERSE: mdl_inverse = data[0];
			REG_GAMMA:   mdl_gamma   = data[GAMMA_W-1:0];
			REG_SCALE:   mdl_scale   = data[SCALE_W-1:0];
			REG_MAX:     mdl_max     = data[MAG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain_all();
		while (pending_samples.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) return SAMPLE_W'($urandom);
		if (pick < 8) return SAMPLE_W'($urandom_range(40000));
		return SAMPLE_W'($urandom_range(255));
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp_ch.valid = 1'b0;
		smp_ch.sample = '0;
		res_ch.ready = 1'b0;
		mdl_inverse = 1'b0;
		mdl_gamma = GAMMA_RST;
		mdl_scale = SCALE_RST;
		mdl_max = MAX_RST;
		mismatch_count = 0;
		quiet_cycles = 0;
		tx_idle_pct = 32;
		rx_idle_pct = 82;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes and the zero and negative cases at reset settings, then in inverse mode
		pending_samples = '{18'sd0, 18'sd1, 18'sd2, 18'sd131071, -18'sd1, -18'sd131072,
			18'sd32768, 18'sd32767, 18'sd32769, 18'sd16384, 18'sd100, 18'sd65535,
			18'sd65536, 18'sd21845, 18'sd43690};
		drain_all();
		write_reg(REG_INVERSE, 1);
		pending_samples = '{18'sd0, 18'sd1, 18'sd131071, -18'sd5, 18'sd32768, 18'sd4};
		drain_all();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 4) begin
				tx_idle_pct = 32; rx_idle_pct = 82;
			end else if (ph < 8) begin
				tx_idle_pct = 82; rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0; rx_idle_pct = 0;
			end
			case (ph)
				0: begin write_reg(REG_INVERSE, 0); write_reg(REG_GAMMA, 1); end
				1: begin write_reg(REG_GAMMA, 65535); write_reg(REG_SCALE, 65535); end
				2: begin write_reg(REG_GAMMA, 0); write_reg(REG_SCALE, 0); end
				3: begin write_reg(REG_MAX, 0); write_reg(REG_GAMMA, 9011); end
				4: begin write_reg(REG_MAX, 131071); write_reg(REG_SCALE, 4096); end
				5: begin write_reg(REG_INVERSE, 1); write_reg(REG_GAMMA, 9011); end
				6: begin write_reg(REG_GAMMA, 65535); write_reg(REG_SCALE, 1); end
				7: begin write_reg(REG_GAMMA, 1); write_reg(REG_SCALE, 65535); end
				8: begin write_reg(REG_MAX, 0); write_reg(REG_GAMMA, 0); end
				9: begin write_reg(REG_MAX, 32768); write_reg(REG_SCALE, 0); end
				default: begin
					write_reg(REG_INVERSE, $urandom_range(1));
					write_reg(REG_GAMMA, $urandom_range(65535));
					write_reg(REG_SCALE, $urandom_range(65535));
					write_reg(REG_MAX, $urandom_range(131071));
				end
			endcase
			for (int k = 0; k < RAND_PER_PHASE; k++)
				pending_samples.push_back(random_sample());
			drain_all();
		end

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("** power_law_transfer: PASSED **");
		end else begin
			$display("** power_law_transfer: FAILED **");
		end
		$finish;
	end

endmodule
